// File: design/gbn_pkg.sv
// ============================================================================
// gbn_pkg: shared types and constants of the Go-Back-N sender
// Widths, register map, event codes, ALU operation codes and the structs that
// travel between the sender's modules.
// ============================================================================
`default_nettype none

package gbn_pkg;

    // Sizes of the sender's state.
    localparam int WINDOW_MAX = 64;
    localparam int SEQ_BITS   = 16;
    localparam int TIMER_BITS = 16;

    // Fixed field widths.
    localparam int MODE_BITS  = 2;
    localparam int ACK_BITS   = 16;
    localparam int OSEQ_BITS  = 16;
    localparam int BYTE_BITS  = 32;
    localparam int WIN_BITS   = 7;
    localparam int CFG_BITS   = 16;

    // Derived sizes.
    localparam int LIM_BITS   = SEQ_BITS + 1;
    localparam int ALU_BITS   = (LIM_BITS > BYTE_BITS) ? LIM_BITS : BYTE_BITS;
    localparam int CNT_BITS   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    // APB register map: register i sits at byte address 4*i.
    localparam int APB_DATA_BITS = 32;
    localparam int REG_COUNT     = 4;
    localparam int REG_IDX_BITS  = $clog2(REG_COUNT);
    localparam int ADDR_BITS     = REG_IDX_BITS + 2;

    localparam logic [REG_IDX_BITS-1:0] REG_WINDOW_SIZE   = REG_IDX_BITS'(0);
    localparam logic [REG_IDX_BITS-1:0] REG_PACKET_COUNT  = REG_IDX_BITS'(1);
    localparam logic [REG_IDX_BITS-1:0] REG_TIMEOUT_TICKS = REG_IDX_BITS'(2);
    localparam logic [REG_IDX_BITS-1:0] REG_FRAME_BYTES   = REG_IDX_BITS'(3);

    // Register reset values.
    localparam logic [WIN_BITS-1:0] RST_WINDOW_SIZE   = WIN_BITS'(8);
    localparam logic [CFG_BITS-1:0] RST_PACKET_COUNT  = CFG_BITS'(10000);
    localparam logic [CFG_BITS-1:0] RST_TIMEOUT_TICKS = CFG_BITS'(100);
    localparam logic [CFG_BITS-1:0] RST_FRAME_BYTES   = CFG_BITS'(1036);

    // Event codes of an input beat.
    typedef enum logic [MODE_BITS-1:0] {
        MODE_START = 2'd0,
        MODE_ACK   = 2'd1,
        MODE_TICK  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef struct packed {
        alu_op_t             op;
        logic [ALU_BITS-1:0] a;
        logic [ALU_BITS-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_BITS-1:0] sum;
        logic                lt;
    } alu_rsp_t;

    typedef struct packed {
        logic [WIN_BITS-1:0] window_size;
        logic [CFG_BITS-1:0] packet_count;
        logic [CFG_BITS-1:0] timeout_ticks;
        logic [CFG_BITS-1:0] frame_bytes;
    } cfg_t;

    typedef struct packed {
        logic [OSEQ_BITS-1:0] seq_num;
        logic                 is_resend;
        logic                 last;
        logic [BYTE_BITS-1:0] bytes_total;
    } result_t;

endpackage

`default_nettype wire

// File: design/gbn_in_if.sv
// ============================================================================
// gbn_in_if: event channel of the Go-Back-N sender
// One beat carries an event code and a cumulative ack number.
// ============================================================================
`default_nettype none

interface gbn_in_if
    import gbn_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [MODE_BITS-1:0] mode;
    logic [ACK_BITS-1:0]  ack_num;

    modport source (output valid, output mode, output ack_num, input ready);
    modport sink   (input valid, input mode, input ack_num, output ready);
endinterface

`default_nettype wire

// File: design/gbn_out_if.sv
// ============================================================================
// gbn_out_if: send channel of the Go-Back-N sender
// One beat describes one frame to transmit.
// ============================================================================
`default_nettype none

interface gbn_out_if
    import gbn_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [OSEQ_BITS-1:0] seq_num;
    logic                 is_resend;
    logic                 last;
    logic [BYTE_BITS-1:0] bytes_total;

    modport source (output valid, output seq_num, output is_resend, output last,
                    output bytes_total, input ready);
    modport sink   (input valid, input seq_num, input is_resend, input last,
                    input bytes_total, output ready);
endinterface

`default_nettype wire

// File: design/gbn_regs.sv
// ============================================================================
// gbn_regs: APB configuration registers
// Window size, packet count, timeout and frame size, with read-back.
// ============================================================================
`default_nettype none

module gbn_regs
    import gbn_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [ADDR_BITS-1:0]     paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output logic                          pready,
    output cfg_t                          cfg
);

    cfg_t                    cfg_reg;
    cfg_t                    cfg_next;
    logic [REG_IDX_BITS-1:0] idx;
    logic                    wr_en;

    assign idx    = paddr[ADDR_BITS-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_WINDOW_SIZE:   cfg_next.window_size   = pwdata[WIN_BITS-1:0];
                REG_PACKET_COUNT:  cfg_next.packet_count  = pwdata[CFG_BITS-1:0];
                REG_TIMEOUT_TICKS: cfg_next.timeout_ticks = pwdata[CFG_BITS-1:0];
                REG_FRAME_BYTES:   cfg_next.frame_bytes   = pwdata[CFG_BITS-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_WINDOW_SIZE:   prdata = APB_DATA_BITS'(cfg_reg.window_size);
            REG_PACKET_COUNT:  prdata = APB_DATA_BITS'(cfg_reg.packet_count);
            REG_TIMEOUT_TICKS: prdata = APB_DATA_BITS'(cfg_reg.timeout_ticks);
            REG_FRAME_BYTES:   prdata = APB_DATA_BITS'(cfg_reg.frame_bytes);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_size   <= RST_WINDOW_SIZE;
            cfg_reg.packet_count  <= RST_PACKET_COUNT;
            cfg_reg.timeout_ticks <= RST_TIMEOUT_TICKS;
            cfg_reg.frame_bytes   <= RST_FRAME_BYTES;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// File: design/gbn_alu.sv
// ============================================================================
// gbn_alu: shared adder and comparator
// Adds, or subtracts and reports a borrow as an unsigned less-than.
// ============================================================================
`default_nettype none

module gbn_alu
    import gbn_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [ALU_BITS-1:0] b_eff;
    logic [ALU_BITS:0]   full;
    logic                is_sub;

    always_comb
    begin
        is_sub  = (req.op == ALU_SUB);
        b_eff   = is_sub ? ~req.b : req.b;
        full    = {1'b0, req.a} + {1'b0, b_eff} + {{ALU_BITS{1'b0}}, is_sub};
        rsp.sum = full[ALU_BITS-1:0];
        // With a + ~b + 1 the carry out is set exactly when a >= b.
        rsp.lt  = is_sub && !full[ALU_BITS];
    end

endmodule

`default_nettype wire

// File: design/gbn_seq.sv
// ============================================================================
// gbn_seq: Go-Back-N sequencer
// Holds the window state and steps the work of each event through the shared ALU.
// ============================================================================
`default_nettype none

module gbn_seq
    import gbn_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_fire,
    input  wire logic [MODE_BITS-1:0] in_mode,
    input  wire logic [ACK_BITS-1:0]  in_ack,
    output logic                      in_ready,
    input  cfg_t                      cfg,
    output alu_req_t                  alu_req,
    input  alu_rsp_t                  alu_rsp,
    input  wire logic                 out_free,
    output logic                      push,
    output result_t                   res
);

    typedef enum logic [13:0] {
        S_IDLE     = 14'h0001,
        S_ACK_LO   = 14'h0002,
        S_ACK_HI   = 14'h0004,
        S_ACK_INC  = 14'h0008,
        S_ACK_TMR  = 14'h0010,
        S_TICK_CMP = 14'h0020,
        S_TICK_DEC = 14'h0040,
        S_LIM_ADD  = 14'h0080,
        S_LIM_MIN  = 14'h0100,
        S_CHK      = 14'h0200,
        S_SUM      = 14'h0400,
        S_INC      = 14'h0800,
        S_LAST     = 14'h1000,
        S_EMIT     = 14'h2000
    } state_t;

    localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(WINDOW_MAX - 1);

    state_t                state_reg, state_next;
    logic [SEQ_BITS-1:0]   base_reg, base_next;
    logic [SEQ_BITS-1:0]   nseq_reg, nseq_next;
    logic                  run_reg, run_next;
    logic [TIMER_BITS-1:0] left_reg, left_next;
    logic [BYTE_BITS-1:0]  sum_reg, sum_next;
    logic [SEQ_BITS-1:0]   cur_reg, cur_next;
    logic [LIM_BITS-1:0]   lim_reg, lim_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [ACK_BITS-1:0]   ack_reg, ack_next;
    logic                  resend_reg, resend_next;
    result_t               res_reg, res_next;
    logic [ALU_BITS-1:0]   win_eff;
    logic [TIMER_BITS-1:0] tmo;

    assign in_ready = (state_reg == S_IDLE);
    assign push     = (state_reg == S_EMIT) && out_free;
    assign res      = res_reg;
    assign tmo      = TIMER_BITS'(cfg.timeout_ticks);

    // Window sizes above the maximum behave as the maximum.
    assign win_eff = (ALU_BITS'(cfg.window_size) > ALU_BITS'(WINDOW_MAX))
                   ? ALU_BITS'(WINDOW_MAX) : ALU_BITS'(cfg.window_size);

    always_comb
    begin
        state_next  = state_reg;
        base_next   = base_reg;
        nseq_next   = nseq_reg;
        run_next    = run_reg;
        left_next   = left_reg;
        sum_next    = sum_reg;
        cur_next    = cur_reg;
        lim_next    = lim_reg;
        cnt_next    = cnt_reg;
        ack_next    = ack_reg;
        resend_next = resend_reg;
        res_next    = res_reg;
        alu_req.op  = ALU_ADD;
        alu_req.a   = '0;
        alu_req.b   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    ack_next = in_ack;
                    cnt_next = '0;
                    unique case (mode_t'(in_mode))
                        MODE_START: state_next = S_LIM_ADD;
                        MODE_ACK:   state_next = S_ACK_LO;
                        MODE_TICK:  state_next = run_reg ? S_TICK_CMP : S_IDLE;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_ACK_LO:
            begin
                // A stale ack below the window base is dropped.
                alu_req.op = ALU_SUB;
                alu_req.a  = ALU_BITS'(ack_reg);
                alu_req.b  = ALU_BITS'(base_reg);
                state_next = alu_rsp.lt ? S_IDLE : S_ACK_HI;
            end
            S_ACK_HI:
            begin
                // An ack for a frame never sent is dropped too.
                alu_req.op = ALU_SUB;
                alu_req.a  = ALU_BITS'(ack_reg);
                alu_req.b  = ALU_BITS'(nseq_reg);
                state_next = alu_rsp.lt ? S_ACK_INC : S_IDLE;
            end
            S_ACK_INC:
            begin
                alu_req.a  = ALU_BITS'(ack_reg);
                alu_req.b  = ALU_BITS'(1);
                base_next  = alu_rsp.sum[SEQ_BITS-1:0];
                state_next = S_ACK_TMR;
            end
            S_ACK_TMR:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = ALU_BITS'(base_reg);
                alu_req.b  = ALU_BITS'(nseq_reg);
                if (alu_rsp.lt)
                begin
                    run_next  = 1'b1;
                    left_next = tmo;
                end
                else
                begin
                    run_next  = 1'b0;
                    left_next = '0;
                end
                state_next = S_LIM_ADD;
            end
            S_TICK_CMP:
            begin
                // Expiry when at most one tick is left.
                alu_req.op = ALU_SUB;
                alu_req.a  = ALU_BITS'(left_reg);
                alu_req.b  = ALU_BITS'(2);
                if (alu_rsp.lt)
                begin
                    resend_next = 1'b1;
                    cur_next    = base_reg;
                    lim_next    = LIM_BITS'(nseq_reg);
                    state_next  = S_CHK;
                end
                else
                begin
                    state_next = S_TICK_DEC;
                end
            end
            S_TICK_DEC:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = ALU_BITS'(left_reg);
                alu_req.b  = ALU_BITS'(1);
                left_next  = alu_rsp.sum[TIMER_BITS-1:0];
                state_next = S_IDLE;
            end
            S_LIM_ADD:
            begin
                alu_req.a  = ALU_BITS'(base_reg);
                alu_req.b  = win_eff;
                lim_next   = alu_rsp.sum[LIM_BITS-1:0];
                state_next = S_LIM_MIN;
            end
            S_LIM_MIN:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = ALU_BITS'(cfg.packet_count);
                alu_req.b  = ALU_BITS'(lim_reg);
                if (alu_rsp.lt)
                begin
                    lim_next = LIM_BITS'(cfg.packet_count);
                end
                resend_next = 1'b0;
                cur_next    = nseq_reg;
                state_next  = S_CHK;
            end
            S_CHK:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = ALU_BITS'(cur_reg);
                alu_req.b  = ALU_BITS'(lim_reg);
                if (alu_rsp.lt)
                begin
                    state_next = S_SUM;
                end
                else
                begin
                    if (resend_reg)
                    begin
                        run_next  = 1'b1;
                        left_next = tmo;
                    end
                    state_next = S_IDLE;
                end
            end
            S_SUM:
            begin
                alu_req.a            = ALU_BITS'(sum_reg);
                alu_req.b            = ALU_BITS'(cfg.frame_bytes);
                sum_next             = alu_rsp.sum[BYTE_BITS-1:0];
                res_next.bytes_total = alu_rsp.sum[BYTE_BITS-1:0];
                res_next.seq_num     = OSEQ_BITS'(cur_reg);
                res_next.is_resend   = resend_reg;
                // The first frame of an empty window starts the timer.
                if (!resend_reg && (base_reg == cur_reg))
                begin
                    run_next  = 1'b1;
                    left_next = tmo;
                end
                state_next = S_INC;
            end
            S_INC:
            begin
                alu_req.a = ALU_BITS'(cur_reg);
                alu_req.b = ALU_BITS'(1);
                cur_next  = alu_rsp.sum[SEQ_BITS-1:0];
                if (!resend_reg)
                begin
                    nseq_next = alu_rsp.sum[SEQ_BITS-1:0];
                end
                state_next = S_LAST;
            end
            S_LAST:
            begin
                alu_req.op    = ALU_SUB;
                alu_req.a     = ALU_BITS'(cur_reg);
                alu_req.b     = ALU_BITS'(lim_reg);
                res_next.last = !alu_rsp.lt || (cnt_reg == CNT_MAX);
                state_next    = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cnt_next = cnt_reg + CNT_BITS'(1);
                    if (res_reg.last)
                    begin
                        if (resend_reg)
                        begin
                            run_next  = 1'b1;
                            left_next = tmo;
                        end
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_SUM;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            base_reg  <= '0;
            nseq_reg  <= '0;
            run_reg   <= 1'b0;
            left_reg  <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            base_reg  <= base_next;
            nseq_reg  <= nseq_next;
            run_reg   <= run_next;
            left_reg  <= left_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        lim_reg    <= lim_next;
        cnt_reg    <= cnt_next;
        ack_reg    <= ack_next;
        resend_reg <= resend_next;
        res_reg    <= res_next;
    end

    // A beat marked last always returns the sequencer to idle.
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (push && res_reg.last) |=> (state_reg == S_IDLE))
        else $error("sequencer kept sending after the last beat");

    // The burst never exceeds the beat cap.
    a_cap_last: assert property (@(posedge clk) disable iff (!rst_n)
        (push && (cnt_reg == CNT_MAX)) |-> res_reg.last)
        else $error("burst ran past the beat cap");

    // Every frame sent lies below its bound.
    a_in_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM) |-> (LIM_BITS'(cur_reg) < lim_reg))
        else $error("frame sent beyond its bound");

    // The byte total advances by one frame size per frame.
    a_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM) |=>
            (sum_reg == $past(sum_reg) + BYTE_BITS'($past(cfg.frame_bytes))))
        else $error("byte total out of step");

endmodule

`default_nettype wire

// File: design/go_back_n_sender.sv
// ============================================================================
// go_back_n_sender: Go-Back-N ARQ sender control
// Turns start, ack and tick events into the sequence of frames to transmit.
// ============================================================================
//
// Each event beat is taken only while the sequencer is idle; the event
// channel is not ready while the sequencer works on it. A start sets the
// window limit first; an accepted ack moves the base and the timer first.
// Each frame sent takes the byte total, the sequence increment and the
// end-of-burst compare, then the hand-off, which waits while the send
// channel stalls. All sums and compares go through a single shared adder.
// The send side has its own output register, so a new event is taken while
// the final frame of the previous one still waits there. Stale acks and acks
// for frames never sent are dropped without any send beat; mode 3 and ticks
// while the timer is stopped do nothing. Configuration is to be written
// through the APB port while the block is idle; the block itself does not
// enforce this.
//
`default_nettype none

module go_back_n_sender
    import gbn_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    gbn_in_if.sink                        in_ch,
    gbn_out_if.source                     out_ch,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [ADDR_BITS-1:0]     paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output logic                          pready
);

    cfg_t     cfg;
    alu_req_t alu_req;
    alu_rsp_t alu_rsp;
    logic     in_ready;
    logic     in_fire;
    logic     out_free;
    logic     push;
    result_t  res;
    logic     ov_reg, ov_next;
    result_t  out_reg;

    gbn_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gbn_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // An event beat is taken only when the sequencer sits idle.
    assign in_ch.ready = in_ready;
    assign in_fire     = in_ch.valid && in_ready;

    gbn_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_mode  (in_ch.mode),
        .in_ack   (in_ch.ack_num),
        .in_ready (in_ready),
        .cfg      (cfg),
        .alu_req  (alu_req),
        .alu_rsp  (alu_rsp),
        .out_free (out_free),
        .push     (push),
        .res      (res)
    );

    // Output register: the next frame may be loaded in the same cycle that
    // the sink takes the current one.
    assign out_free = !ov_reg || out_ch.ready;

    always_comb
    begin
        if (push)
        begin
            ov_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            ov_next = 1'b0;
        end
        else
        begin
            ov_next = ov_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else
        begin
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_reg <= res;
        end
    end

    assign out_ch.valid       = ov_reg;
    assign out_ch.seq_num     = out_reg.seq_num;
    assign out_ch.is_resend   = out_reg.is_resend;
    assign out_ch.last        = out_reg.last;
    assign out_ch.bytes_total = out_reg.bytes_total;

endmodule

`default_nettype wire
